>>> hdl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants of the ultrasonic echo ranger
// Event codes, datapath widths, arithmetic constants and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package uer_pkg;

    // Defaults for the top-level parameters
    localparam int TIMER_FREQ_HZ_DEF = 1000000;
    localparam int NUM_SENSORS_DEF   = 5;

    // Input opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_ECHO  = 2'd1;
    localparam logic [1:0] OP_OVF   = 2'd2;

    // Result event kinds
    localparam logic [1:0] EV_TRIGGER = 2'd0;
    localparam logic [1:0] EV_DONE    = 2'd1;
    localparam logic [1:0] EV_TIMEOUT = 2'd2;

    // Field widths
    localparam int OP_W   = 2;
    localparam int CH_W   = 3;
    localparam int CAP_W  = 16;
    localparam int US_W   = 16;
    localparam int MM_W   = 14;
    localparam int TEMP_W = 7;

    // Divider widths: dividend up to 65535 * 1000, divisor the 12-bit speed
    localparam int DVD_W = 26;
    localparam int DVS_W = 12;
    localparam int CNT_W = $clog2(DVD_W + 1);

    // ticks * 1000 / ticks_per_ms == (ticks * recip) >> 32, recip being
    // 2^32 * 1000 / ticks_per_ms rounded up; exact for 16-bit ticks and
    // ticks_per_ms from 1000 to 48000
    localparam int RECIP_W    = 33;
    localparam int TICK_SHIFT = 32;

    // Arithmetic constants
    localparam logic [TEMP_W-1:0] TEMP_RESET = 7'd22;
    localparam int MUL_K      = 1000;
    localparam int SOS_BASE   = 3313;
    localparam int SOS_SLOPE  = 6;
    localparam int SOS_LOSS   = 17;
    // floor(s / 100) == (s * 1311) >> 17 for every s below 4681
    localparam int SOS_RECIP  = 1311;
    localparam int SOS_SHIFT  = 17;
    localparam int US_MAX     = 65535;

    // Controller to datapath commands
    typedef struct packed {
        logic       load_in;   // capture the accepted word
        logic       set_chan;  // take the start channel as active channel
        logic       mul1;      // us = ticks * 1000 / ticks per ms, by reciprocal
        logic       mul2;      // dividend = us * 1000, divisor = speed of sound
        logic       out_load;  // load the result word
        logic [1:0] kind;      // event kind of the result word
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic chan_ok;   // start channel below the sensor count
        logic div_busy;  // divider still iterating
    } t_status;

endpackage

>>> hdl/uer_datapath.sv
// ----------------------------------------------------------------------------
// uer_datapath: arithmetic and result registers of the echo ranger
// Holds the temperature register, derives the speed of sound, converts
// ticks to microseconds by a reciprocal multiply, runs the bit-serial
// divider for the distance conversion and holds the result word.
// ----------------------------------------------------------------------------
module uer_datapath #(
    parameter int TIMER_FREQ_HZ = uer_pkg::TIMER_FREQ_HZ_DEF,
    parameter int NUM_SENSORS   = uer_pkg::NUM_SENSORS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [uer_pkg::TEMP_W-1:0]  i_cfg_wr_data,
    input  logic [uer_pkg::CH_W-1:0]    i_sensor_channel,
    input  logic [uer_pkg::CAP_W-1:0]   i_capture_count,
    input  uer_pkg::t_cmd               i_cmd,
    output uer_pkg::t_status            o_status,
    output logic [uer_pkg::OP_W-1:0]    o_event_kind,
    output logic [uer_pkg::CH_W-1:0]    o_result_channel,
    output logic [uer_pkg::US_W-1:0]    o_echo_us,
    output logic [uer_pkg::MM_W-1:0]    o_distance_mm
);

    localparam int DVD_W    = uer_pkg::DVD_W;
    localparam int DVS_W    = uer_pkg::DVS_W;
    localparam int CNT_W    = uer_pkg::CNT_W;
    localparam int RECIP_W  = uer_pkg::RECIP_W;
    localparam int PROD_W   = uer_pkg::CAP_W + RECIP_W;
    localparam int Q_W      = PROD_W - uer_pkg::TICK_SHIFT;
    localparam int TickDivR = TIMER_FREQ_HZ / 1000;
    localparam int TickDiv  = (TickDivR == 0) ? 1 : TickDivR;
    localparam logic [RECIP_W-1:0] TickRecip =
        RECIP_W'(((64'd1 << uer_pkg::TICK_SHIFT) * 64'd1000 + 64'(TickDiv) - 64'd1)
                 / 64'(TickDiv));

    // Configuration and speed of sound
    logic [uer_pkg::TEMP_W-1:0] r_temp;
    logic [12:0]                sos_raw;
    logic [22:0]                sos_prod;
    logic [12:0]                r_sos_raw;
    logic [5:0]                 r_sos_q;
    logic [11:0]                speed;

    // Captured word and active channel
    logic [uer_pkg::CAP_W-1:0]  r_cap;
    logic [uer_pkg::CH_W-1:0]   r_chan;

    // Tick conversion
    logic [PROD_W-1:0]          us_prod;
    logic [Q_W-1:0]             us_q;
    logic [uer_pkg::US_W-1:0]   us_sat;
    logic [uer_pkg::US_W-1:0]   r_us;

    // Divider
    logic [DVD_W-1:0]           r_dvd;
    logic [DVS_W-1:0]           r_dvs;
    logic [DVS_W-1:0]           r_rem;
    logic [CNT_W-1:0]           r_cnt;
    logic [DVS_W:0]             rem_sh;
    logic                       rem_ge;
    logic [DVS_W:0]             rem_nx;

    // Result word
    logic [uer_pkg::OP_W-1:0]   r_out_kind;
    logic [uer_pkg::CH_W-1:0]   r_out_chan;
    logic [uer_pkg::US_W-1:0]   r_out_us;
    logic [uer_pkg::MM_W-1:0]   r_out_mm;

    // Hold the air temperature
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp <= uer_pkg::TEMP_RESET;
        end else if (i_cfg_wr_en) begin
            r_temp <= i_cfg_wr_data;
        end
    end

    // Derive speed = s - (s / 100) * 17 with s = 3313 + 6 * T, in two steps
    assign sos_raw  = 13'(uer_pkg::SOS_BASE) + 13'(r_temp) * 13'(uer_pkg::SOS_SLOPE);
    assign sos_prod = 23'(sos_raw) * 23'(uer_pkg::SOS_RECIP);

    always_ff @(posedge i_clk) begin
        r_sos_raw <= sos_raw;
        r_sos_q   <= sos_prod[uer_pkg::SOS_SHIFT +: 6];
    end

    assign speed = 12'(r_sos_raw - 13'(r_sos_q) * 13'(uer_pkg::SOS_LOSS));

    // Capture the accepted word and the active channel
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cap <= i_capture_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= '0;
        end else if (i_cmd.set_chan) begin
            r_chan <= i_sensor_channel;
        end
    end

    // Convert ticks to microseconds and saturate
    assign us_prod = PROD_W'(r_cap) * PROD_W'(TickRecip);
    assign us_q    = us_prod[PROD_W-1:uer_pkg::TICK_SHIFT];
    assign us_sat  = (us_q > Q_W'(uer_pkg::US_MAX)) ? uer_pkg::US_W'(uer_pkg::US_MAX)
                                                    : us_q[uer_pkg::US_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_us <= us_sat;
        end
    end

    // Restoring divider step, one quotient bit per cycle
    assign rem_sh = {r_rem, r_dvd[DVD_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_dvs});
    assign rem_nx = rem_ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;

    // Load the divider from the multiplier or advance it
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul2) begin
            r_dvd <= DVD_W'(r_us) * DVD_W'(uer_pkg::MUL_K);
            r_dvs <= DVS_W'(speed);
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= rem_nx[DVS_W-1:0];
            r_dvd <= {r_dvd[DVD_W-2:0], rem_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.mul2) begin
            r_cnt <= CNT_W'(DVD_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Load the result word; zero the measurement fields unless done
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_kind <= i_cmd.kind;
            r_out_chan <= r_chan;
            if (i_cmd.kind == uer_pkg::EV_DONE) begin
                r_out_us <= r_us;
                r_out_mm <= r_dvd[uer_pkg::MM_W:1];
            end else begin
                r_out_us <= '0;
                r_out_mm <= '0;
            end
        end
    end

    assign o_status.chan_ok  = ({1'b0, i_sensor_channel} < (uer_pkg::CH_W + 1)'(NUM_SENSORS));
    assign o_status.div_busy = (r_cnt != '0);

    assign o_event_kind     = r_out_kind;
    assign o_result_channel = r_out_chan;
    assign o_echo_us        = r_out_us;
    assign o_distance_mm    = r_out_mm;

endmodule

>>> hdl/uer_controller.sv
// ----------------------------------------------------------------------------
// uer_controller: sequencing state machine of the echo ranger
// Decodes accepted words against the measurement phase, steps the datapath
// through both conversions and owns the result valid flag.
// ----------------------------------------------------------------------------
module uer_controller (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [uer_pkg::OP_W-1:0]  i_opcode,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    input  uer_pkg::t_status          i_status,
    output uer_pkg::t_cmd             o_cmd
);

    typedef enum logic [4:0] {
        S_READY = 5'b00001,
        S_MUL1  = 5'b00010,
        S_MUL2  = 5'b00100,
        S_DIV2  = 5'b01000,
        S_PUT   = 5'b10000
    } t_state;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_ARMED   = 2'd1;
    localparam logic [1:0] PH_MEASURE = 2'd2;

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_phase;
    logic [1:0] n_phase;
    logic [1:0] r_kind;
    logic [1:0] n_kind;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       accept;
    logic       out_free;

    assign accept   = i_in_valid && (r_state == S_READY);
    assign out_free = !r_out_valid || !i_out_stall;

    // Decode and sequence
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_kind      = r_kind;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.kind  = r_kind;
        o_cmd.load_in = accept;
        case (r_state)
            S_READY: begin
                if (accept) begin
                    case (i_opcode)
                        uer_pkg::OP_START: begin
                            if (i_status.chan_ok) begin
                                o_cmd.set_chan = 1'b1;
                                n_phase = PH_ARMED;
                                n_kind  = uer_pkg::EV_TRIGGER;
                                n_state = S_PUT;
                            end
                        end
                        uer_pkg::OP_ECHO: begin
                            if (r_phase == PH_ARMED) begin
                                n_phase = PH_MEASURE;
                            end else if (r_phase == PH_MEASURE) begin
                                n_phase = PH_IDLE;
                                n_kind  = uer_pkg::EV_DONE;
                                n_state = S_MUL1;
                            end
                        end
                        uer_pkg::OP_OVF: begin
                            if (r_phase == PH_ARMED || r_phase == PH_MEASURE) begin
                                n_phase = PH_IDLE;
                                n_kind  = uer_pkg::EV_TIMEOUT;
                                n_state = S_PUT;
                            end
                        end
                        default: begin
                            // drop unused opcode
                        end
                    endcase
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_DIV2;
            end
            S_DIV2: begin
                if (!i_status.div_busy) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_READY;
                end
            end
            default: begin
                n_state = S_READY;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_READY;
            r_phase     <= PH_IDLE;
            r_kind      <= uer_pkg::EV_TRIGGER;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_READY);
    assign o_out_valid = r_out_valid;

endmodule

>>> hdl/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: echo-ranging controller for shared-timer sensors
// A start word arms a sensor and returns a trigger word; the first echo
// edge starts the measurement and the second returns the echo width in
// microseconds and the one-way distance in millimetres, compensated for the
// air temperature register; a timer overflow while armed or measuring
// returns a timeout word. An ignored word takes only the accept, a trigger or
// timeout the accept and the result load, and a finished measurement the
// accept, a reciprocal multiply for ticks to microseconds, the divider load,
// 26 steps of the one-bit-per-cycle divider for the distance, a finish
// check and the result load. A new word is taken as soon as the previous
// one has been handed to the result register, even while that result is
// still stalled; a stalled result holds back only the next result load.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger #(
    parameter int TIMER_FREQ_HZ = uer_pkg::TIMER_FREQ_HZ_DEF,
    parameter int NUM_SENSORS   = uer_pkg::NUM_SENSORS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [uer_pkg::TEMP_W-1:0]  i_cfg_wr_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [uer_pkg::OP_W-1:0]    i_opcode,
    input  logic [uer_pkg::CH_W-1:0]    i_sensor_channel,
    input  logic [uer_pkg::CAP_W-1:0]   i_capture_count,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [uer_pkg::OP_W-1:0]    o_event_kind,
    output logic [uer_pkg::CH_W-1:0]    o_result_channel,
    output logic [uer_pkg::US_W-1:0]    o_echo_us,
    output logic [uer_pkg::MM_W-1:0]    o_distance_mm
);

    uer_pkg::t_cmd    cmd;
    uer_pkg::t_status status;

    // Sequencing
    uer_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Arithmetic and result word
    uer_datapath #(
        .TIMER_FREQ_HZ (TIMER_FREQ_HZ),
        .NUM_SENSORS   (NUM_SENSORS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_sensor_channel (i_sensor_channel),
        .i_capture_count  (i_capture_count),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_event_kind     (o_event_kind),
        .o_result_channel (o_result_channel),
        .o_echo_us        (o_echo_us),
        .o_distance_mm    (o_distance_mm)
    );

`ifndef SYNTHESIS
    // Trigger and timeout words carry no measurement
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_kind != uer_pkg::EV_DONE)
            |-> (o_echo_us == '0 && o_distance_mm == '0))
        else $error("nonzero measurement on trigger or timeout word");

    // No word is taken while the divider iterates
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.div_busy |-> o_in_stall)
        else $error("input accepted during division");

    // Results only name existing sensors
    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_result_channel} < (uer_pkg::CH_W + 1)'(NUM_SENSORS)))
        else $error("result channel out of range");

    // A result load always raises valid next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_out_valid)
        else $error("result loaded without valid");
`endif

endmodule

>>> bench/ultrasonic_echo_ranger_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_test: self-checking bench for the echo ranger
// Drives start, echo and overflow words through the valid/stall input port,
// predicts each trigger, measurement and timeout word with its own model of
// the ranging state and the temperature-compensated distance, and checks
// every result word field by field. The air temperature register is swept
// over its extremes, 100 and random settings between phases of random traffic.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_test;

    localparam int TIMER_FREQ_HZ   = uer_pkg::TIMER_FREQ_HZ_DEF;
    localparam int NUM_SENSORS     = uer_pkg::NUM_SENSORS_DEF;
    localparam logic [uer_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES   = 64;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int WORDS_PER_PHASE = 200;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ARMED,
        PH_MEASURING
    } t_ranger_phase;

    typedef struct packed {
        logic [uer_pkg::OP_W-1:0]  kind;
        logic [uer_pkg::CH_W-1:0]  chan;
        logic [uer_pkg::US_W-1:0]  us;
        logic [uer_pkg::MM_W-1:0]  mm;
    } t_echo_word;

    // Ranging state, temperature and the queue of result words still due
    class t_echo_scoreboard;
        logic [uer_pkg::TEMP_W-1:0] air_temp;
        t_ranger_phase              phase;
        logic [uer_pkg::CH_W-1:0]   active_chan;
        t_echo_word                 awaited[$];
        int unsigned                errors;

        function new();
            air_temp    = uer_pkg::TEMP_RESET;
            phase       = PH_IDLE;
            active_chan = '0;
            errors      = 0;
        endfunction

        // Convert a capture count to microseconds and a one-way distance
        function t_echo_word finish_measure(logic [uer_pkg::CAP_W-1:0] count);
            longint unsigned ticks_per_ms;
            longint unsigned micros;
            longint unsigned speed;
            longint unsigned range_mm;
            t_echo_word      w;
            ticks_per_ms = TIMER_FREQ_HZ / 1000;
            if (ticks_per_ms == 0)
                ticks_per_ms = 1;
            micros = (longint'(count) * uer_pkg::MUL_K) / ticks_per_ms;
            if (micros > uer_pkg::US_MAX)
                micros = uer_pkg::US_MAX;
            speed = uer_pkg::SOS_BASE + uer_pkg::SOS_SLOPE * int'(air_temp);
            speed = speed - (speed / 100) * uer_pkg::SOS_LOSS;
            range_mm = (micros * uer_pkg::MUL_K) / speed / 2;
            w = '{kind: uer_pkg::EV_DONE, chan: active_chan,
                  us: micros[uer_pkg::US_W-1:0], mm: range_mm[uer_pkg::MM_W-1:0]};
            return w;
        endfunction

        // Advance the state for an accepted word; return 1 unless it is ignored
        function bit note_word(logic [uer_pkg::OP_W-1:0] op, logic [uer_pkg::CH_W-1:0] ch,
                               logic [uer_pkg::CAP_W-1:0] count);
            t_echo_word w;
            case (op)
                uer_pkg::OP_START: begin
                    if (int'(ch) >= NUM_SENSORS)
                        return 0;
                    active_chan = ch;
                    phase       = PH_ARMED;
                    w = '{kind: uer_pkg::EV_TRIGGER, chan: ch, us: '0, mm: '0};
                    awaited.push_back(w);
                    return 1;
                end
                uer_pkg::OP_ECHO: begin
                    if (phase == PH_ARMED) begin
                        phase = PH_MEASURING;
                        return 1;
                    end
                    if (phase == PH_MEASURING) begin
                        awaited.push_back(finish_measure(count));
                        phase = PH_IDLE;
                        return 1;
                    end
                    return 0;
                end
                uer_pkg::OP_OVF: begin
                    if (phase == PH_IDLE)
                        return 0;
                    w = '{kind: uer_pkg::EV_TIMEOUT, chan: active_chan, us: '0, mm: '0};
                    awaited.push_back(w);
                    phase = PH_IDLE;
                    return 1;
                end
                default: return 0;
            endcase
        endfunction

        // Compare a result word with the oldest one due
        function void check_word(t_echo_word got);
            t_echo_word want;
            if (awaited.size() == 0) begin
                $error("result word with none due: kind %0d channel %0d",
                       got.kind, got.chan);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.kind !== want.kind) begin
                $error("event_kind: expected %0d, actual %0d", want.kind, got.kind);
                errors++;
            end
            if (got.chan !== want.chan) begin
                $error("result_channel: expected %0d, actual %0d", want.chan, got.chan);
                errors++;
            end
            if (got.us !== want.us) begin
                $error("echo_us: expected %0d, actual %0d", want.us, got.us);
                errors++;
            end
            if (got.mm !== want.mm) begin
                $error("distance_mm: expected %0d, actual %0d", want.mm, got.mm);
                errors++;
            end
        endfunction
    endclass

    logic                        i_clk            = 1'b0;
    logic                        i_rst_n          = 1'b0;
    logic                        i_cfg_wr_en      = 1'b0;
    logic [uer_pkg::TEMP_W-1:0]  i_cfg_wr_data    = '0;
    logic                        i_in_valid       = 1'b0;
    logic                        o_in_stall;
    logic [uer_pkg::OP_W-1:0]    i_opcode         = '0;
    logic [uer_pkg::CH_W-1:0]    i_sensor_channel = '0;
    logic [uer_pkg::CAP_W-1:0]   i_capture_count  = '0;
    logic                        o_out_valid;
    logic                        i_out_stall      = 1'b0;
    logic [uer_pkg::OP_W-1:0]    o_event_kind;
    logic [uer_pkg::CH_W-1:0]    o_result_channel;
    logic [uer_pkg::US_W-1:0]    o_echo_us;
    logic [uer_pkg::MM_W-1:0]    o_distance_mm;

    t_echo_scoreboard sb = new();
    bit               idling_on   = 1'b0;
    int               live_words  = 0;
    int               stall_left  = 0;
    int               cycle_count = 0;

    ultrasonic_echo_ranger #(
        .TIMER_FREQ_HZ (TIMER_FREQ_HZ),
        .NUM_SENSORS   (NUM_SENSORS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_sensor_channel (i_sensor_channel),
        .i_capture_count  (i_capture_count),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_event_kind     (o_event_kind),
        .o_result_channel (o_result_channel),
        .o_echo_us        (o_echo_us),
        .o_distance_mm    (o_distance_mm)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Abort a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[ultrasonic_echo_ranger] ERROR");
        $finish;
    end

    // Check accepted result words, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_word({o_event_kind, o_result_channel, o_echo_us, o_distance_mm});
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(0, 15);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Present one input word, hold it until accepted
    task automatic send_word(input logic [uer_pkg::OP_W-1:0] op,
                             input logic [uer_pkg::CH_W-1:0] ch,
                             input logic [uer_pkg::CAP_W-1:0] count);
        int gap;
        gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_opcode         <= op;
        i_sensor_channel <= ch;
        i_capture_count  <= count;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        if (sb.note_word(op, ch, count))
            live_words++;
    endtask

    // Drop valid, wait for every due word, then let the block settle
    task automatic drain_words();
        i_in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_temp(input logic [uer_pkg::TEMP_W-1:0] temp_c);
        drain_words();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= temp_c;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.air_temp = temp_c;
    endtask

    // A full measurement: start word, opening edge, closing edge
    task automatic run_measure(input logic [uer_pkg::CH_W-1:0] ch,
                               input logic [uer_pkg::CAP_W-1:0] count);
        send_word(uer_pkg::OP_START, ch, '0);
        send_word(uer_pkg::OP_ECHO, ch, '0);
        send_word(uer_pkg::OP_ECHO, ch, count);
    endtask

    function automatic logic [uer_pkg::CAP_W-1:0] pick_count();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return uer_pkg::CAP_W'($urandom_range(1, 255));
            3: return uer_pkg::CAP_W'($urandom_range(60000, 65534));
            default: return uer_pkg::CAP_W'($urandom);
        endcase
    endfunction

    // Mostly well-formed measurements with random content, some noise
    task automatic run_random(input int target, input bit allow_idle);
        int                       goal;
        logic [uer_pkg::CH_W-1:0] ch;
        goal = live_words + target;
        idling_on = allow_idle;
        while (live_words < goal) begin
            if (allow_idle && $urandom_range(0, 29) == 0)
                idling_on = !idling_on;
            ch = uer_pkg::CH_W'($urandom_range(0, NUM_SENSORS - 1));
            case ($urandom_range(0, 9))
                0, 1: send_word(uer_pkg::OP_W'($urandom_range(0, 3)),
                                uer_pkg::CH_W'($urandom), uer_pkg::CAP_W'($urandom));
                2: begin
                    send_word(uer_pkg::OP_START, ch, uer_pkg::CAP_W'($urandom));
                    send_word(uer_pkg::OP_OVF, uer_pkg::CH_W'($urandom),
                              uer_pkg::CAP_W'($urandom));
                end
                default: begin
                    send_word(uer_pkg::OP_START, ch, uer_pkg::CAP_W'($urandom));
                    send_word(uer_pkg::OP_ECHO, uer_pkg::CH_W'($urandom),
                              uer_pkg::CAP_W'($urandom));
                    case ($urandom_range(0, 7))
                        0: send_word(uer_pkg::OP_OVF, uer_pkg::CH_W'($urandom),
                                     uer_pkg::CAP_W'($urandom));
                        1: ; // leave it measuring, the next start drops it
                        default: send_word(uer_pkg::OP_ECHO, uer_pkg::CH_W'($urandom),
                                           pick_count());
                    endcase
                end
            endcase
        end
    endtask

    initial begin
        int temps[3] = '{0, 127, 100};
        logic [uer_pkg::TEMP_W-1:0] temp_c;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idling_on = 1'b1;

        // Ignored words while idle and out-of-range starts
        send_word(uer_pkg::OP_OVF, 3'd0, 16'h0000);
        send_word(uer_pkg::OP_ECHO, 3'd7, 16'hFFFF);
        send_word(OP_UNUSED, 3'd7, 16'hFFFF);
        send_word(uer_pkg::OP_START, 3'd7, 16'hFFFF);
        send_word(uer_pkg::OP_START, uer_pkg::CH_W'(NUM_SENSORS), 16'h0000);
        // Timeout while armed
        send_word(uer_pkg::OP_START, 3'd0, 16'h0000);
        send_word(uer_pkg::OP_OVF, 3'd5, 16'h0000);
        // Shortest and longest echo
        run_measure(uer_pkg::CH_W'(NUM_SENSORS - 1), 16'h0000);
        run_measure(3'd1, 16'hFFFF);
        // Restart while armed, then while measuring
        send_word(uer_pkg::OP_START, 3'd2, 16'h0000);
        send_word(uer_pkg::OP_START, 3'd3, 16'h0000);
        send_word(uer_pkg::OP_ECHO, 3'd0, 16'h1234);
        send_word(uer_pkg::OP_START, 3'd4, 16'h0000);
        send_word(uer_pkg::OP_ECHO, 3'd0, 16'h0000);
        send_word(uer_pkg::OP_ECHO, 3'd0, 16'd12345);
        // Timeout while measuring, then an edge back in idle
        send_word(uer_pkg::OP_START, 3'd2, 16'h0000);
        send_word(uer_pkg::OP_ECHO, 3'd2, 16'h0000);
        send_word(uer_pkg::OP_OVF, 3'd0, 16'h0000);
        send_word(uer_pkg::OP_ECHO, 3'd0, 16'h5555);

        // Sweep the air temperature, extremes first
        for (int i = 0; i < 6; i++) begin
            temp_c = (i < 3) ? uer_pkg::TEMP_W'(temps[i])
                             : uer_pkg::TEMP_W'($urandom_range(0, 127));
            write_temp(temp_c);
            idling_on = (i != 5);
            run_measure(uer_pkg::CH_W'($urandom_range(0, NUM_SENSORS - 1)), 16'hFFFF);
            run_measure(uer_pkg::CH_W'($urandom_range(0, NUM_SENSORS - 1)), pick_count());
            run_random(WORDS_PER_PHASE, i != 5);
        end

        drain_words();
        if (sb.errors == 0)
            $display("[ultrasonic_echo_ranger] OK");
        else
            $display("[ultrasonic_echo_ranger] ERROR");
        $finish;
    end

endmodule
